// ===== design/sli_pkg.sv =====
// Shared constants for the sorted insertion list: field widths, request types
// and status codes. No dependencies.
package sli_pkg;

  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned ECOUNT_W  = 5;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_DELETE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

endpackage

// ===== design/sorted_list_insert_delete_unit.sv =====
// Sorted insertion list: one request at a time, entries in sli_ram, a less-than and
// an equality comparator stepping over the list one entry per cycle under a small sequencer.
// Insert: walks from the tail down, moving entries >= value up; S_INS0 at the head;
// delete: scans every entry from the head, moving those after the match down;
// refused or trivial requests go straight to S_FIN, which waits for a free output.
// Reset clears the count and the sequencer; RAM contents are not cleared.
module sorted_list_insert_delete_unit
  import sli_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       req_type_i,
  input  logic signed [VALUE_W-1:0]  value_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [STATUS_W-1:0]        status_o,
  output logic [ECOUNT_W-1:0]        entry_count_o,
  output logic signed [VALUE_W-1:0]  smallest_value_o,
  output logic                       list_empty_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;
  localparam logic [2:0] S_INS0 = 3'd2;
  localparam logic [2:0] S_DEL  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]                state_q, state_d;
  logic [CW-1:0]             idx_q, idx_d;
  logic [CW-1:0]             count_q, count_d;
  logic signed [VALUE_W-1:0] val_q, val_d;
  logic signed [VALUE_W-1:0] small_q, small_d;
  logic                      found_q, found_d;
  logic [STATUS_W-1:0]       status_q, status_d;

  logic                      out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]       out_status_q, out_status_d;
  logic [CW-1:0]             out_count_q, out_count_d;
  logic signed [VALUE_W-1:0] out_small_q, out_small_d;

  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  logic [VALUE_W-1:0]        wr_data;
  logic [AW-1:0]             rd_addr;
  logic [VALUE_W-1:0]        rd_data;

  logic                      is_less;
  logic                      is_equal;
  logic                      in_acc;
  logic                      out_free;
  logic [CW-1:0]             idx_inc;
  logic [CW-1:0]             idx_dec;
  logic [CW+ECOUNT_W-1:0]    count_ext;

  sli_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign is_less  = $signed(rd_data) < val_q;
  assign is_equal = rd_data == val_q;
  assign idx_inc  = idx_q + ONE_C;
  assign idx_dec  = idx_q - ONE_C;
  assign in_stall_o = state_q != S_IDLE;
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    count_d  = count_q;
    val_d    = val_q;
    small_d  = small_q;
    found_d  = found_q;
    status_d = status_q;
    wr_en    = 1'b0;
    wr_addr  = '0;
    wr_data  = val_q;
    rd_addr  = '0;

    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_count_d  = out_count_q;
    out_small_d  = out_small_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          val_d    = value_i;
          found_d  = 1'b0;
          status_d = STATUS_DONE;
          if (req_type_i == REQ_INSERT) begin
            if (count_q == CAP_C) begin
              status_d = STATUS_FULL;
              state_d  = S_FIN;
            end else if (count_q == '0) begin
              wr_en   = 1'b1;
              wr_addr = '0;
              wr_data = value_i;
              small_d = value_i;
              count_d = ONE_C;
              state_d = S_FIN;
            end else begin
              idx_d   = count_q - ONE_C;
              rd_addr = idx_d[AW-1:0];
              state_d = S_INS;
            end
          end else begin
            if (count_q == '0) begin
              status_d = STATUS_NOT_FOUND;
              state_d  = S_FIN;
            end else begin
              idx_d   = '0;
              rd_addr = '0;
              state_d = S_DEL;
            end
          end
        end
      end
      S_INS: begin
        wr_en   = 1'b1;
        wr_addr = idx_inc[AW-1:0];
        if (!is_less) begin
          wr_data = rd_data;
          if (idx_q == '0) begin
            state_d = S_INS0;
          end else begin
            idx_d   = idx_dec;
            rd_addr = idx_dec[AW-1:0];
          end
        end else begin
          wr_data = val_q;
          count_d = count_q + ONE_C;
          state_d = S_FIN;
        end
      end
      S_INS0: begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = val_q;
        small_d = val_q;
        count_d = count_q + ONE_C;
        state_d = S_FIN;
      end
      S_DEL: begin
        if (found_q) begin
          wr_en   = 1'b1;
          wr_addr = idx_dec[AW-1:0];
          wr_data = rd_data;
          if (idx_dec == '0) begin
            small_d = rd_data;
          end
        end else if (is_equal) begin
          found_d = 1'b1;
        end
        if (idx_inc == count_q) begin
          if (found_d) begin
            count_d = count_q - ONE_C;
          end else begin
            status_d = STATUS_NOT_FOUND;
          end
          state_d = S_FIN;
        end else begin
          idx_d   = idx_inc;
          rd_addr = idx_inc[AW-1:0];
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_count_d  = count_q;
          out_small_d  = small_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    val_q        <= val_d;
    small_q      <= small_d;
    status_q     <= status_d;
    out_status_q <= out_status_d;
    out_count_q  <= out_count_d;
    out_small_q  <= out_small_d;
  end

  assign count_ext        = {{ECOUNT_W{1'b0}}, out_count_q};
  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign entry_count_o    = count_ext[ECOUNT_W-1:0];
  assign list_empty_o     = out_count_q == '0;
  assign smallest_value_o = list_empty_o ? '0 : out_small_q;

endmodule

// ===== design/sli_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module sli_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== dv/tb_sorted_list_insert_delete_unit.sv =====
// Testbench for sorted_list_insert_delete_unit: directed and random insert and
// delete requests, each result checked against a queue model of the sorted list.
// Depends on sli_pkg and the unit itself.
module tb_sorted_list_insert_delete_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import sli_pkg::*;

  localparam int unsigned LIST_DEPTH   = 16;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned MAX_REPORTS  = 10;

  localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic [ECOUNT_W-1:0]       count;
    logic signed [VALUE_W-1:0] smallest;
    logic                      empty;
  } list_result_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic                      req_type_i;
  logic signed [VALUE_W-1:0] value_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic [STATUS_W-1:0]       status_o;
  logic [ECOUNT_W-1:0]       entry_count_o;
  logic signed [VALUE_W-1:0] smallest_value_o;
  logic                      list_empty_o;

  logic signed [VALUE_W-1:0] sorted_shadow[$];
  list_result_t              pending_results[$];
  bit                        no_idle;
  int unsigned               idle_pct;
  int unsigned               stall_pct;
  int unsigned               mismatches;
  int unsigned               cycle_count;

  sorted_list_insert_delete_unit #(
    .CAPACITY(LIST_DEPTH)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .value_i         (value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .entry_count_o   (entry_count_o),
    .smallest_value_o(smallest_value_o),
    .list_empty_o    (list_empty_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic list_result_t list_after_request(input logic kind,
                                                      input logic signed [VALUE_W-1:0] val);
    list_result_t res;
    int unsigned  pos;
    res.status = STATUS_DONE;
    pos = 0;
    if (kind == REQ_INSERT) begin
      if (sorted_shadow.size() >= LIST_DEPTH) begin
        res.status = STATUS_FULL;
      end else begin
        while (pos < sorted_shadow.size() && sorted_shadow[pos] < val) pos++;
        sorted_shadow.insert(pos, val);
      end
    end else begin
      while (pos < sorted_shadow.size() && sorted_shadow[pos] != val) pos++;
      if (pos >= sorted_shadow.size()) begin
        res.status = STATUS_NOT_FOUND;
      end else begin
        sorted_shadow.delete(pos);
      end
    end
    res.count    = ECOUNT_W'(sorted_shadow.size());
    res.smallest = (sorted_shadow.size() != 0) ? sorted_shadow[0] : '0;
    res.empty    = (sorted_shadow.size() == 0);
    return res;
  endfunction

  function automatic logic signed [VALUE_W-1:0] random_value();
    case ($urandom_range(9, 0))
      0: return VALUE_MIN;
      1: return VALUE_MAX;
      2, 3, 4, 5: return int'($urandom_range(8, 0)) - 4;
      default: return $urandom();
    endcase
  endfunction

  function automatic int unsigned pick_rate();
    case ($urandom_range(3, 0))
      0: return 0;
      1: return 5;
      2: return 25;
      default: return 50;
    endcase
  endfunction

  // valid stays high after acceptance; the next request or an idle gap replaces it
  task automatic send_request(input logic kind, input logic signed [VALUE_W-1:0] val);
    int unsigned gap;
    gap = 0;
    if (!no_idle && $urandom_range(99, 0) < idle_pct) gap = $urandom_range(8, 1);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= kind;
    value_i    <= val;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    pending_results.push_back(list_after_request(kind, val));
  endtask

  task automatic test_delete_from_empty();
    send_request(REQ_DELETE, '0);
    send_request(REQ_DELETE, VALUE_MIN);
  endtask

  task automatic test_fill_to_capacity();
    send_request(REQ_INSERT, VALUE_MAX);
    send_request(REQ_INSERT, VALUE_MIN);
    send_request(REQ_INSERT, '0);
    send_request(REQ_INSERT, 32'sd7);
    send_request(REQ_INSERT, 32'sd7);
    for (int k = 0; k < LIST_DEPTH - 5; k++) send_request(REQ_INSERT, 100 - 10 * k);
    send_request(REQ_INSERT, -32'sd1);
  endtask

  task automatic test_delete_cases();
    send_request(REQ_DELETE, 32'sd5);
    send_request(REQ_DELETE, 32'sd7);
    send_request(REQ_DELETE, VALUE_MIN);
    send_request(REQ_DELETE, VALUE_MAX);
    send_request(REQ_INSERT, -32'sd1);
  endtask

  // alternate between filling towards capacity and draining towards empty
  task automatic test_random_traffic(input int unsigned n_req);
    bit                        filling;
    logic                      kind;
    logic signed [VALUE_W-1:0] val;
    filling = 1'b1;
    for (int unsigned i = 0; i < n_req; i++) begin
      if (i % 50 == 0) begin
        idle_pct  = pick_rate();
        stall_pct = pick_rate();
      end
      if (sorted_shadow.size() == LIST_DEPTH && $urandom_range(3, 0) == 0) filling = 1'b0;
      else if (sorted_shadow.size() == 0) filling = 1'b1;
      if ($urandom_range(3, 0) == 0) kind = filling ? REQ_DELETE : REQ_INSERT;
      else kind = filling ? REQ_INSERT : REQ_DELETE;
      if (kind == REQ_DELETE && sorted_shadow.size() != 0 && $urandom_range(9, 0) < 7) begin
        val = sorted_shadow[$urandom_range(sorted_shadow.size() - 1, 0)];
      end else begin
        val = random_value();
      end
      send_request(kind, val);
    end
  endtask

  task automatic test_back_to_back();
    no_idle = 1'b1;
    test_random_traffic(150);
  endtask

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!no_idle && $urandom_range(99, 0) < stall_pct) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(8, 1)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : check_result
    list_result_t got;
    list_result_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      got.status   = status_o;
      got.count    = entry_count_o;
      got.smallest = smallest_value_o;
      got.empty    = list_empty_o;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result: status %0d count %0d smallest %0d empty %0b",
                   $time, got.status, got.count, got.smallest, got.empty);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.count !== want.count ||
            got.smallest !== want.smallest || got.empty !== want.empty) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: mismatch: status %0d/%0d count %0d/%0d smallest %0d/%0d empty %0b/%0b",
                     $time, want.status, got.status, want.count, got.count,
                     want.smallest, got.smallest, want.empty, got.empty);
        end
      end
    end
  end

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    req_type_i = REQ_INSERT;
    value_i    = '0;
    no_idle    = 1'b0;
    idle_pct   = 20;
    stall_pct  = 20;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_delete_from_empty();
    test_fill_to_capacity();
    test_delete_cases();
    test_random_traffic(800);
    test_back_to_back();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
